### rtl/wsfhp_pkg.sv
// ----------------------------------------------------------------------------
// wsfhp_pkg
// Types and codes shared by the WebSocket frame header parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfhp_pkg;

   // Result kinds
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // Opcodes the parser understands
   localparam logic [3:0] OP_CONT   = 4'd0;
   localparam logic [3:0] OP_TEXT   = 4'd1;
   localparam logic [3:0] OP_BINARY = 4'd2;
   localparam logic [3:0] OP_CLOSE  = 4'd8;
   localparam logic [3:0] OP_PING   = 4'd9;
   localparam logic [3:0] OP_PONG   = 4'd10;

   // Short-length escape codes in the second header byte
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam int LEN_W = 63;

   // Register map
   localparam logic REG_RSV_ENABLE = 1'b0;

   typedef struct packed {
      logic       fin;
      logic [2:0] rsv;
      logic [3:0] opcode;
      logic       masked;
   } flags_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic             fin;
      logic [2:0]       rsv;
      logic [3:0]       opcode;
      logic             masked;
      logic [LEN_W-1:0] length;
      logic [31:0]      key;
      logic [7:0]       payload;
      logic             eof;
   } result_type;

endpackage

`default_nettype wire

### rtl/websocket_frame_header_parser.sv
// ----------------------------------------------------------------------------
// websocket_frame_header_parser
// Byte-stream WebSocket frame decoder: header fields, length, mask key and
// counted payload pass-through.
// ----------------------------------------------------------------------------
// Feed the frame stream in one byte per req transaction. The block accepts a
// byte every clock cycle while req_ready is high; each byte is decoded in the
// cycle it is accepted and any result is registered in the output buffer.
// Header bytes produce no result until the header is complete (after the mask
// key if the mask bit is set); then one header transaction (kind 0) is sent,
// followed by one kind-1 transaction per payload byte, the last one flagged
// with end_of_frame. A zero-length frame flags end_of_frame on its header. A
// first byte with an unknown opcode yields one kind-2 transaction and the
// parser waits for a new frame start. Payload bytes pass through as received,
// without unmasking. A two-entry output buffer absorbs consumer stalls:
// req_ready only drops after rsp_ready has been low long enough to fill both
// entries. Program reserved_bits_enabled at CSR byte address 0 (bit 2 rsv1,
// bit 1 rsv2, bit 0 rsv3) while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_header_parser (
   input  wire logic        clock,
   input  wire logic        reset,

   // byte stream in
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,

   // results out
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_result_kind,
   output logic             rsp_final_fragment,
   output logic [2:0]       rsp_reserved_flags,
   output logic [3:0]       rsp_frame_opcode,
   output logic             rsp_is_masked,
   output logic [62:0]      rsp_frame_length,
   output logic [31:0]      rsp_mask_key,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_end_of_frame,

   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import wsfhp_pkg::*;

   logic [2:0] rsv_en_ff, rsv_en_in;
   logic       csr_write;
   logic       accept;
   logic       res_valid;
   result_type res;
   result_type out_data;

   // Register file: one word, word-addressed by paddr[2]; low bits ignored.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      rsv_en_in = rsv_en_ff;
      if (csr_write && csr_paddr[2] == REG_RSV_ENABLE) rsv_en_in = csr_pwdata[2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) rsv_en_ff <= 3'd0;
      else       rsv_en_ff <= rsv_en_in;
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == REG_RSV_ENABLE) csr_prdata = {29'd0, rsv_en_ff};
   end

   // Take a byte whenever the skid slot is free.
   assign accept = req_valid & req_ready;

   wsfhp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .rsv_enable (rsv_en_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   wsfhp_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res),
      .can_accept (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_data)
   );

   // Fan the result register out onto the result ports.
   assign rsp_result_kind    = out_data.kind;
   assign rsp_final_fragment = out_data.fin;
   assign rsp_reserved_flags = out_data.rsv;
   assign rsp_frame_opcode   = out_data.opcode;
   assign rsp_is_masked      = out_data.masked;
   assign rsp_frame_length   = out_data.length;
   assign rsp_mask_key       = out_data.key;
   assign rsp_payload_byte   = out_data.payload;
   assign rsp_end_of_frame   = out_data.eof;

endmodule

`default_nettype wire

### rtl/wsfhp_parse.sv
// ----------------------------------------------------------------------------
// wsfhp_parse
// Per-byte header decoder: phase, length, mask and payload count registers,
// plus the logic that forms at most one result per accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfhp_parse (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            data_byte,
   input  wire logic [2:0]            rsv_enable,
   output logic                       res_valid,
   output wsfhp_pkg::result_type      res
);
   import wsfhp_pkg::*;

   localparam logic [2:0] PH_START   = 3'd0;
   localparam logic [2:0] PH_LEN     = 3'd1;
   localparam logic [2:0] PH_EXTLEN  = 3'd2;
   localparam logic [2:0] PH_MASK    = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   logic [2:0]       phase_ff,  phase_in;
   logic [3:0]       count_ff,  count_in;
   logic [LEN_W-1:0] len_ff,    len_in;
   logic [LEN_W-1:0] remain_ff, remain_in;
   logic [31:0]      key_ff,    key_in;
   flags_type        flags_ff,  flags_in;

   flags_type        start_flags;
   logic             op_known;
   logic             len_done;
   logic             hdr_done;
   logic             eof;

   always_comb begin
      start_flags.fin    = data_byte[7];
      start_flags.rsv    = data_byte[6:4] & rsv_enable;
      start_flags.opcode = data_byte[3:0];
      start_flags.masked = 1'b0;
      op_known = (data_byte[3:0] inside {OP_CONT, OP_TEXT, OP_BINARY,
                                         OP_CLOSE, OP_PING, OP_PONG});
   end

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      len_in    = len_ff;
      remain_in = remain_ff;
      key_in    = key_ff;
      flags_in  = flags_ff;
      res_valid = 1'b0;
      res       = '0;
      len_done  = 1'b0;
      hdr_done  = 1'b0;
      eof       = 1'b0;

      if (accept) begin
         case (phase_ff)
            PH_START: begin
               if (!op_known) begin
                  res_valid  = 1'b1;
                  res.kind   = KIND_ERROR;
                  res.fin    = start_flags.fin;
                  res.rsv    = start_flags.rsv;
                  res.opcode = start_flags.opcode;
               end else begin
                  flags_in  = start_flags;
                  len_in    = '0;
                  remain_in = '0;
                  key_in    = '0;
                  count_in  = 4'd0;
                  phase_in  = PH_LEN;
               end
            end
            PH_LEN: begin
               flags_in.masked = data_byte[7];
               len_in          = '0;
               if (data_byte[6:0] == LEN_EXT64) begin
                  count_in = 4'd8;
                  phase_in = PH_EXTLEN;
               end else if (data_byte[6:0] == LEN_EXT16) begin
                  count_in = 4'd2;
                  phase_in = PH_EXTLEN;
               end else begin
                  len_in   = {{(LEN_W-7){1'b0}}, data_byte[6:0]};
                  len_done = 1'b1;
               end
            end
            PH_EXTLEN: begin
               // top bit of a 64-bit length shifts out and is dropped
               len_in = {len_ff[LEN_W-9:0], data_byte};
               if (count_ff != 4'd0) count_in = count_ff - 4'd1;
               if (count_ff <= 4'd1) len_done = 1'b1;
            end
            PH_MASK: begin
               key_in = {key_ff[23:0], data_byte};
               if (count_ff != 4'd0) count_in = count_ff - 4'd1;
               if (count_ff <= 4'd1) hdr_done = 1'b1;
            end
            PH_PAYLOAD: begin
               if (remain_ff != '0) remain_in = remain_ff - {{(LEN_W-1){1'b0}}, 1'b1};
               res_valid   = 1'b1;
               res.kind    = KIND_PAYLOAD;
               res.fin     = flags_ff.fin;
               res.rsv     = flags_ff.rsv;
               res.opcode  = flags_ff.opcode;
               res.masked  = flags_ff.masked;
               res.length  = len_ff;
               res.key     = flags_ff.masked ? key_ff : 32'd0;
               res.payload = data_byte;
               res.eof     = (remain_ff <= {{(LEN_W-1){1'b0}}, 1'b1});
               if (res.eof) phase_in = PH_START;
            end
            default: begin
               phase_in = PH_START;
            end
         endcase

         if (len_done) begin
            if (flags_in.masked) begin
               count_in = 4'd4;
               phase_in = PH_MASK;
            end else begin
               hdr_done = 1'b1;
            end
         end

         if (hdr_done) begin
            eof        = (len_in == '0);
            res_valid  = 1'b1;
            res.kind   = KIND_HEADER;
            res.fin    = flags_in.fin;
            res.rsv    = flags_in.rsv;
            res.opcode = flags_in.opcode;
            res.masked = flags_in.masked;
            res.length = len_in;
            res.key    = flags_in.masked ? key_in : 32'd0;
            res.eof    = eof;
            if (eof) begin
               phase_in = PH_START;
            end else begin
               remain_in = len_in;
               phase_in  = PH_PAYLOAD;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         count_ff  <= 4'd0;
         len_ff    <= '0;
         remain_ff <= '0;
         key_ff    <= 32'd0;
         flags_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         len_ff    <= len_in;
         remain_ff <= remain_in;
         key_ff    <= key_in;
         flags_ff  <= flags_in;
      end
   end

endmodule

`default_nettype wire

### rtl/wsfhp_out_buf.sv
// ----------------------------------------------------------------------------
// wsfhp_out_buf
// Two-entry result register with skid slot, so input flow keeps going while
// the consumer stalls, until the skid slot fills.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfhp_out_buf (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire wsfhp_pkg::result_type push_data,
   output logic                       can_accept,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output wsfhp_pkg::result_type      out_data
);
   import wsfhp_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff,       main_in;
   result_type skid_ff,       skid_in;
   logic       pop;

   assign pop        = main_valid_ff & out_ready;
   assign can_accept = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // no push can arrive while the skid slot is full
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire
